// ===== sv/tsrl_pkg.sv =====
`timescale 1ns / 1ps

package tsrl_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int RING_DEPTH_DEF = 8;

   localparam int MODE_W = 2;
   localparam int RAMP_W = 10;
   localparam int DECEL_W = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PREFILL = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_POT_LOW = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POT_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESC_MIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPORT_MAX = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHILL_MAX = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHILL_RAMP = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPORT_RAMP = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECEL = 3'd7;

   localparam logic [SAMPLE_BITS-1:0] POT_LOW_RST = 12'd0;
   localparam logic [SAMPLE_BITS-1:0] POT_HIGH_RST = 12'd4095;
   localparam logic [SAMPLE_BITS-1:0] ESC_MIN_RST = 12'd1035;
   localparam logic [SAMPLE_BITS-1:0] SPORT_MAX_RST = 12'd1950;
   localparam logic [SAMPLE_BITS-1:0] CHILL_MAX_RST = 12'd1600;
   localparam logic [RAMP_W-1:0] CHILL_RAMP_RST = 10'd4;
   localparam logic [RAMP_W-1:0] SPORT_RAMP_RST = 10'd8;
   localparam logic [DECEL_W-1:0] DECEL_RST = 4'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } tsrl_div_stat_type;

endpackage

// ===== sv/tsrl_if.sv =====
`timescale 1ns / 1ps

interface tsrl_req_if import tsrl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [MODE_W-1:0]      mode;
   logic [SAMPLE_BITS-1:0] pot_sample;
   logic                   sport_mode;
   logic [SAMPLE_BITS-1:0] fill_value;

   modport source (output valid, mode, pot_sample, sport_mode, fill_value, input ready);
   modport sink (input valid, mode, pot_sample, sport_mode, fill_value, output ready);
endinterface

interface tsrl_rsp_if import tsrl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] smoothed_pwm;
   logic [SAMPLE_BITS-1:0] drive_pwm;

   modport source (output valid, smoothed_pwm, drive_pwm, input ready);
   modport sink (input valid, smoothed_pwm, drive_pwm, output ready);
endinterface

// ===== sv/tsrl_div.sv =====
`timescale 1ns / 1ps

module tsrl_div import tsrl_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [2*SAMPLE_BITS-1:0] numer,
   input  logic [SAMPLE_BITS-1:0]   denom,
   output logic [SAMPLE_BITS-1:0]   quotient,
   output tsrl_div_stat_type        stat
);

   localparam int CNT_W = $clog2(SAMPLE_BITS + 1);

   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] quo_ff, quo_in;
   logic [SAMPLE_BITS-1:0] den_ff, den_in;
   logic [SAMPLE_BITS:0]   trial;
   logic [SAMPLE_BITS:0]   trial_sub;
   logic                   fits;

   // quotient is known to fit, so the upper half of the dividend starts as remainder
   assign trial = {rem_ff, quo_ff[SAMPLE_BITS-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign fits = trial >= {1'b0, den_ff};

   always_comb begin
      cnt_in = cnt_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      if (start) begin
         cnt_in = CNT_W'(SAMPLE_BITS);
         rem_in = numer[2*SAMPLE_BITS-1:SAMPLE_BITS];
         quo_in = numer[SAMPLE_BITS-1:0];
         den_in = denom;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
         rem_in = fits ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
         quo_in = {quo_ff[SAMPLE_BITS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;

`ifndef SYNTHESIS
   a_done_after_last_step : assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == CNT_W'(1) && !start) |=> done_ff)
      else $error("divider done missing after last step");
   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> cnt_ff == '0)
      else $error("divider done while still iterating");
   a_done_pulse : assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done longer than one cycle");
`endif

endmodule

// ===== sv/throttle_smooth_ramp_limiter.sv =====
`timescale 1ns / 1ps
// sample tick: map the pot reading (by the shared 12-step divider, skipped when the pot
// range is flat), push it into the ring, average the N ring entries present with the same
// divider after a one-read-per-cycle ring walk, then slew-limit the drive
// prefill writes every ring entry; clear goes straight to the result; status read averages the ring (not when empty)
// one word in flight; the next word is taken while a result waits in the output register
// synchronous reset: registers to defaults, last drive to 1035, ring empty; no clearing pass

module throttle_smooth_ramp_limiter import tsrl_pkg::*; #(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   tsrl_req_if.sink               req_ch,
   tsrl_rsp_if.source             rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int SUMW = SAMPLE_BITS + CW;
   localparam int SB = SAMPLE_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAP,
      ST_MAP_WAIT,
      ST_PUSH,
      ST_SUM,
      ST_SUM_LAST,
      ST_AVG_WAIT,
      ST_SLEW,
      ST_FILL,
      ST_DONE
   } state_type;

   logic [SB-1:0]      pot_low_ff, pot_high_ff, esc_min_ff, sport_max_ff, chill_max_ff;
   logic [RAMP_W-1:0]  chill_ramp_ff, sport_ramp_ff;
   logic [DECEL_W-1:0] decel_ff;

   state_type          state_ff, state_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [SB-1:0]      pot_ff, pot_in;
   logic               sport_ff, sport_in;
   logic [SB-1:0]      fill_ff, fill_in;
   logic               neg_ff, neg_in;
   logic [SB-1:0]      mapped_ff, mapped_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      slot_ff, slot_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [SUMW-1:0]    sum_ff, sum_in;
   logic [SB-1:0]      avg_ff, avg_in;
   logic [SB-1:0]      last_ff, last_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic [SB-1:0]      rsp_avg_ff, rsp_avg_in;
   logic [SB-1:0]      rsp_drive_ff, rsp_drive_in;

   logic [SB-1:0]      ring_mem [RING_DEPTH];
   logic [SB-1:0]      rd_data_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [SB-1:0]      mem_wdata;

   logic                  div_start;
   logic [2*SB-1:0]       div_num;
   logic [SB-1:0]         div_den;
   logic [SB-1:0]         div_quo;
   tsrl_div_stat_type     div_stat;

   logic [SB-1:0]         top_pwm;
   logic [RAMP_W-1:0]     ramp;
   logic                  pot_flat;
   logic [SB-1:0]         pot_clamp;
   logic [SB-1:0]         pot_diff;
   logic [SB-1:0]         pot_span;
   logic signed [SB:0]    out_span;
   logic [SB-1:0]         span_mag;
   logic [2*SB-1:0]       product;
   logic [SUMW-1:0]       sum_total;
   logic signed [SB+1:0]  mapped_calc;
   logic [RAMP_W+DECEL_W-1:0] fall_lim;
   logic signed [SB+2:0]  delta;
   logic signed [SB+2:0]  lim;
   logic signed [SB+2:0]  delta_cl;
   logic signed [SB+3:0]  drive_raw;
   logic [SB-1:0]         drive_cl;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pot_low_ff <= POT_LOW_RST;
         pot_high_ff <= POT_HIGH_RST;
         esc_min_ff <= ESC_MIN_RST;
         sport_max_ff <= SPORT_MAX_RST;
         chill_max_ff <= CHILL_MAX_RST;
         chill_ramp_ff <= CHILL_RAMP_RST;
         sport_ramp_ff <= SPORT_RAMP_RST;
         decel_ff <= DECEL_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_POT_LOW: pot_low_ff <= csr_wdata;
            CSR_POT_HIGH: pot_high_ff <= csr_wdata;
            CSR_ESC_MIN: esc_min_ff <= csr_wdata;
            CSR_SPORT_MAX: sport_max_ff <= csr_wdata;
            CSR_CHILL_MAX: chill_max_ff <= csr_wdata;
            CSR_CHILL_RAMP: chill_ramp_ff <= csr_wdata[RAMP_W-1:0];
            CSR_SPORT_RAMP: sport_ramp_ff <= csr_wdata[RAMP_W-1:0];
            CSR_DECEL: decel_ff <= csr_wdata[DECEL_W-1:0];
            default: ;
         endcase
      end
   end

   // mapping datapath
   assign top_pwm = sport_ff ? sport_max_ff : chill_max_ff;
   assign ramp = sport_ff ? sport_ramp_ff : chill_ramp_ff;
   assign pot_flat = (pot_high_ff <= pot_low_ff);
   assign pot_clamp = (pot_ff < pot_low_ff) ? pot_low_ff :
                      (pot_ff > pot_high_ff) ? pot_high_ff : pot_ff;
   assign pot_diff = pot_clamp - pot_low_ff;
   assign pot_span = pot_high_ff - pot_low_ff;
   assign out_span = $signed({1'b0, top_pwm}) - $signed({1'b0, esc_min_ff});
   assign span_mag = out_span[SB] ? SB'(-out_span) : out_span[SB-1:0];
   assign product = pot_diff * span_mag;
   assign mapped_calc = neg_ff ? $signed({2'b00, esc_min_ff}) - $signed({2'b00, div_quo})
                               : $signed({2'b00, esc_min_ff}) + $signed({2'b00, div_quo});

   // ring sum and divider operands
   assign sum_total = sum_ff + {{CW{1'b0}}, rd_data_ff};
   assign div_start = (state_ff == ST_MAP && !pot_flat) || (state_ff == ST_SUM_LAST);
   assign div_num = (state_ff == ST_MAP) ? product : {{(2*SB-SUMW){1'b0}}, sum_total};
   assign div_den = (state_ff == ST_MAP) ? pot_span : {{(SB-CW){1'b0}}, count_ff};

   tsrl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_num),
      .denom    (div_den),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // slew limit and final clamp
   assign fall_lim = ramp * decel_ff;
   assign delta = $signed({3'b000, avg_ff}) - $signed({3'b000, last_ff});
   assign lim = (delta > 0) ? $signed({5'b00000, ramp})
                            : $signed({1'b0, fall_lim});
   assign delta_cl = (delta > lim) ? lim : (delta < -lim) ? -lim : delta;
   assign drive_raw = $signed({4'b0000, last_ff}) + $signed({delta_cl[SB+2], delta_cl});
   assign drive_cl = (drive_raw < $signed({4'b0000, esc_min_ff})) ? esc_min_ff :
                     (drive_raw > $signed({4'b0000, top_pwm})) ? top_pwm :
                     drive_raw[SB-1:0];

   // ring memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= ring_mem[idx_ff];
   end

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      pot_in = pot_ff;
      sport_in = sport_ff;
      fill_in = fill_ff;
      neg_in = neg_ff;
      mapped_in = mapped_ff;
      count_in = count_ff;
      slot_in = slot_ff;
      idx_in = idx_ff;
      rd_vld_in = 1'b0;
      sum_in = sum_ff;
      avg_in = avg_ff;
      last_in = last_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ch.ready;
      rsp_avg_in = rsp_avg_ff;
      rsp_drive_in = rsp_drive_ff;
      mem_we = 1'b0;
      mem_waddr = slot_ff;
      mem_wdata = mapped_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               mode_in = req_ch.mode;
               pot_in = req_ch.pot_sample;
               sport_in = req_ch.sport_mode;
               fill_in = req_ch.fill_value;
               idx_in = '0;
               sum_in = '0;
               case (req_ch.mode)
                  MODE_TICK: state_in = ST_MAP;
                  MODE_CLEAR: begin
                     last_in = esc_min_ff;
                     count_in = '0;
                     slot_in = '0;
                     avg_in = '0;
                     state_in = ST_DONE;
                  end
                  MODE_PREFILL: state_in = ST_FILL;
                  default: begin
                     if (count_ff == '0) begin
                        avg_in = '0;
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_SUM;
                     end
                  end
               endcase
            end
         end
         ST_MAP: begin
            neg_in = out_span[SB];
            if (pot_flat) begin
               mapped_in = esc_min_ff;
               state_in = ST_PUSH;
            end else begin
               state_in = ST_MAP_WAIT;
            end
         end
         ST_MAP_WAIT: begin
            if (div_stat.done) begin
               mapped_in = mapped_calc[SB-1:0];
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            mem_we = 1'b1;
            slot_in = (slot_ff == AW'(RING_DEPTH - 1)) ? '0 : slot_ff + AW'(1);
            if (count_ff < CW'(RING_DEPTH)) begin
               count_in = count_ff + CW'(1);
            end
            idx_in = '0;
            sum_in = '0;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            rd_vld_in = 1'b1;
            if (rd_vld_ff) begin
               sum_in = sum_total;
            end
            if (CW'(idx_ff) == count_ff - CW'(1)) begin
               state_in = ST_SUM_LAST;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_SUM_LAST: begin
            state_in = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_stat.done) begin
               avg_in = div_quo;
               state_in = (mode_ff == MODE_TICK) ? ST_SLEW : ST_DONE;
            end
         end
         ST_SLEW: begin
            last_in = drive_cl;
            state_in = ST_DONE;
         end
         ST_FILL: begin
            mem_we = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = fill_ff;
            if (idx_ff == AW'(RING_DEPTH - 1)) begin
               count_in = CW'(RING_DEPTH);
               slot_in = '0;
               avg_in = fill_ff;
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_ch.ready) begin
               rsp_vld_in = 1'b1;
               rsp_avg_in = avg_ff;
               rsp_drive_in = last_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         slot_ff <= '0;
         last_ff <= ESC_MIN_RST;
         rd_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         slot_ff <= slot_in;
         last_ff <= last_in;
         rd_vld_ff <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      mode_ff <= mode_in;
      pot_ff <= pot_in;
      sport_ff <= sport_in;
      fill_ff <= fill_in;
      neg_ff <= neg_in;
      mapped_ff <= mapped_in;
      idx_ff <= idx_in;
      sum_ff <= sum_in;
      avg_ff <= avg_in;
      rsp_avg_ff <= rsp_avg_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_vld_ff;
   assign rsp_ch.smoothed_pwm = rsp_avg_ff;
   assign rsp_ch.drive_pwm = rsp_drive_ff;

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(RING_DEPTH))
      else $error("ring count above depth");
   a_div_free : assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");
   a_leave_idle : assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> state_ff != ST_IDLE)
      else $error("accepted word did not start work");
   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word raised outside done");
`endif

endmodule
